[sv/fha_pkg.sv]
`timescale 1ns / 1ps

package fha_pkg;

  localparam int PoolSize = 64;
  localparam int HandleW  = 6;
  localparam int KindW    = 2;
  localparam int StatusW  = 2;

  // request kinds
  localparam logic [KindW-1:0] KIND_ALLOC     = 2'd0;
  localparam logic [KindW-1:0] KIND_TRY_ALLOC = 2'd1;
  localparam logic [KindW-1:0] KIND_FREE      = 2'd2;

  // result status codes
  localparam logic [StatusW-1:0] STATUS_OK        = 2'd0;
  localparam logic [StatusW-1:0] STATUS_NONE_FREE = 2'd1;
  localparam logic [StatusW-1:0] STATUS_NOT_ALLOC = 2'd2;
  localparam logic [StatusW-1:0] STATUS_EXHAUSTED = 2'd3;

  typedef struct packed {
    logic [KindW-1:0]   kind;
    logic [HandleW-1:0] handle_in;
  } req_t;

  typedef struct packed {
    logic [HandleW-1:0] handle_out;
    logic [StatusW-1:0] status;
  } rsp_t;

endpackage

[sv/fifo_handle_allocator_core.sv]
`timescale 1ns / 1ps

// Handle allocator: a pool of POOL_SIZE numbered handles with a FIFO free list.
// Request channel (in_valid_i / in_ready_o / in_req_i): allocate, try-allocate or free.
// Result channel (out_valid_o / out_ready_i / out_rsp_o): exactly one result beat per
// request beat, in request order.
// Allocate reuses the oldest freed handle, else mints the next fresh one, else reports
// the pool exhausted. Try-allocate only reuses. Free checks the allocated bitmap.
// A request accepted into the request register is executed in the execute step, which
// registers its result beat and raises out_valid_o once the result register is free.
// The block takes no new request until the last one is done. Each request reads the
// free-list RAM and the bitmap RAM (registered read), then writes back in the execute
// step; the next request is taken only after that write-back.
// Reset: the bitmap RAM is cleared by a sweep over all POOL_SIZE entries, one entry a cycle,
// with in_ready_o low. Free-list contents are never cleared; the count covers them.
// Stall: the result register holds a beat until taken. A finished request waits in
// the execute step while the previous result is still pending; in_ready_o stays low.
module fifo_handle_allocator_core #(
  parameter int POOL_SIZE = fha_pkg::PoolSize
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  fha_pkg::req_t in_req_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output fha_pkg::rsp_t out_rsp_o
);

  localparam int IdxW = $clog2(POOL_SIZE);
  localparam int CntW = $clog2(POOL_SIZE + 1);
  localparam int HW   = fha_pkg::HandleW;

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_EXEC
  } state_e;

  state_e          state_q, state_d;
  fha_pkg::req_t   req_q, req_d;
  fha_pkg::rsp_t   out_q, out_d;
  logic            out_valid_q, out_valid_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [CntW-1:0] fresh_q, fresh_d;

  // free-list RAM ports
  logic            q_we;
  logic [IdxW-1:0] q_waddr;
  logic [HW-1:0]   q_wdata;
  logic [HW-1:0]   q_rdata;

  // bitmap RAM ports
  logic            m_we;
  logic [IdxW-1:0] m_waddr;
  logic            m_wdata;
  logic            m_rdata;

  logic accept;
  logic out_free;
  logic is_alloc;
  logic free_hit;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign is_alloc   = (req_q.kind == fha_pkg::KIND_ALLOC) ||
                      (req_q.kind == fha_pkg::KIND_TRY_ALLOC);
  // handles at or beyond the pool size never count as allocated
  assign free_hit   = (int'(req_q.handle_in) < POOL_SIZE) && m_rdata;

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    head_d      = head_q;
    tail_d      = tail_q;
    clr_d       = clr_q;
    cnt_d       = cnt_q;
    fresh_d     = fresh_q;
    q_we        = 1'b0;
    q_waddr     = tail_q;
    q_wdata     = req_q.handle_in;
    m_we        = 1'b0;
    m_waddr     = clr_q;
    m_wdata     = 1'b0;

    unique case (state_q)
      S_CLEAR: begin
        m_we  = 1'b1;
        clr_d = clr_q + 1'b1;
        if (clr_q == IdxW'(POOL_SIZE - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          req_d   = in_req_i;
          state_d = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_d.handle_out = '0;
          out_d.status     = fha_pkg::STATUS_OK;
          if (is_alloc) begin
            if (cnt_q != '0) begin
              // reuse oldest freed handle
              out_d.handle_out = q_rdata;
              head_d = (head_q == IdxW'(POOL_SIZE - 1)) ? '0 : head_q + 1'b1;
              cnt_d  = cnt_q - 1'b1;
              if (int'(q_rdata) < POOL_SIZE) begin
                m_we    = 1'b1;
                m_waddr = IdxW'(q_rdata);
                m_wdata = 1'b1;
              end
            end else if (req_q.kind == fha_pkg::KIND_TRY_ALLOC) begin
              out_d.status = fha_pkg::STATUS_NONE_FREE;
            end else if (fresh_q < CntW'(POOL_SIZE)) begin
              // mint a fresh handle
              out_d.handle_out = HW'(fresh_q);
              fresh_d = fresh_q + 1'b1;
              m_we    = 1'b1;
              m_waddr = IdxW'(fresh_q);
              m_wdata = 1'b1;
            end else begin
              out_d.status = fha_pkg::STATUS_EXHAUSTED;
            end
          end else if (req_q.kind == fha_pkg::KIND_FREE) begin
            if (free_hit) begin
              m_we    = 1'b1;
              m_waddr = IdxW'(req_q.handle_in);
              m_wdata = 1'b0;
              if (cnt_q < CntW'(POOL_SIZE)) begin
                q_we   = 1'b1;
                tail_d = (tail_q == IdxW'(POOL_SIZE - 1)) ? '0 : tail_q + 1'b1;
                cnt_d  = cnt_q + 1'b1;
              end
            end else begin
              out_d.status = fha_pkg::STATUS_NOT_ALLOC;
            end
          end
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      req_q       <= '0;
      out_q       <= '0;
      out_valid_q <= 1'b0;
      head_q      <= '0;
      tail_q      <= '0;
      clr_q       <= '0;
      cnt_q       <= '0;
      fresh_q     <= '0;
    end else begin
      state_q     <= state_d;
      req_q       <= req_d;
      out_q       <= out_d;
      out_valid_q <= out_valid_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      clr_q       <= clr_d;
      cnt_q       <= cnt_d;
      fresh_q     <= fresh_d;
    end
  end

  // free list, read at the head on every accepted beat
  fha_ram #(
    .Depth (POOL_SIZE),
    .Width (HW)
  ) u_queue_ram (
    .clk_i   (clk_i),
    .we_i    (q_we),
    .waddr_i (q_waddr),
    .wdata_i (q_wdata),
    .re_i    (accept),
    .raddr_i (head_q),
    .rdata_o (q_rdata)
  );

  // allocated bitmap, read at the handle to free
  fha_ram #(
    .Depth (POOL_SIZE),
    .Width (1)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (m_we),
    .waddr_i (m_waddr),
    .wdata_i (m_wdata),
    .re_i    (accept),
    .raddr_i (IdxW'(in_req_i.handle_in)),
    .rdata_o (m_rdata)
  );

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // free list never holds more than the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(POOL_SIZE))
    else $error("free list count beyond pool size");

  // minted handles never exceed the pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    fresh_q <= CntW'(POOL_SIZE))
    else $error("fresh counter beyond pool size");

  // only minted handles can be on the free list
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= fresh_q)
    else $error("free list holds more handles than were minted");

  // an accepted beat enters the execute step in the next cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_EXEC)
    else $error("accepted beat not executed");

  // a pending result is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> $stable(out_q))
    else $error("pending result overwritten");

endmodule

[sv/fha_ram.sv]
`timescale 1ns / 1ps

// 1W1R synchronous RAM, registered read data
module fha_ram #(
  parameter int Depth = fha_pkg::PoolSize,
  parameter int Width = fha_pkg::HandleW
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
